[rtl/core/lpht_pkg.sv]
// shared types and constants for the linear probe hash table
package lpht_pkg;

   localparam int KEY_W     = 32;
   localparam int PAY_W     = 32;
   localparam int CNT_W     = 11;
   localparam int STATUS_W  = 3;
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 11;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LIMIT     = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES = 1'd1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_FIX,
      S_READ,
      S_CHECK,
      S_WRITE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic div_step;
      logic fix;
      logic rd;
      logic advance;
      logic commit;
      logic set_status;
      logic [STATUS_W-1:0] status;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic div_done;
      logic is_insert;
      logic is_find;
      logic limit_hit;
      logic slot_active;
      logic slot_used;
      logic key_match;
      logic wrapped;
      logic rsp_busy;
   } sts_type;

endpackage

[rtl/core/lpht_if.sv]
// valid ready channel interface
interface lpht_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/core/linear_probe_hash_table.sv]
// top level of the linear probe hash table
// an operation runs a 32-step remainder by the table size, then the home slot fix,
// a read and check per probed slot, a write step on success, and the result load
// throughput: one operation at a time; next transfer taken the cycle after the result load
// the result register lets a new item in while the last result waits
// reset: synchronous, then a clearing pass over every slot with no input transfer taken
module linear_probe_hash_table #(
   parameter int SLOTS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   lpht_if.sink                           req,
   lpht_if.source                         rsp,
   input  logic                           csr_write,
   input  logic [lpht_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lpht_pkg::CSR_W-1:0]     csr_data
);
   import lpht_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [STATUS_W-1:0] r_status;
   logic [PAY_W-1:0]    r_pay;
   logic [CNT_W-1:0]    r_cnt;

   lpht_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .sts(sts), .cmd(cmd)
   );

   lpht_dp #(.SLOTS(SLOTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_operation(req.data[OP_W+KEY_W+PAY_W-1 -: OP_W]),
      .req_key(req.data[KEY_W+PAY_W-1 -: KEY_W]),
      .req_payload(req.data[PAY_W-1:0]),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_status(r_status), .rsp_found_payload(r_pay), .rsp_entry_count(r_cnt)
   );

   assign rsp.data = {r_status, r_pay, r_cnt};

endmodule

[rtl/core/lpht_ctrl.sv]
// controller state machine of the hash table
module lpht_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lpht_pkg::sts_type   sts,
   output lpht_pkg::cmd_type   cmd
);
   import lpht_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (sts.clear_done) state_in = S_IDLE;
         S_IDLE:  if (req_valid) state_in = S_DIV;
         S_DIV:   if (sts.div_done) state_in = S_FIX;
         S_FIX: begin
            if (sts.is_insert && sts.limit_hit) state_in = S_RESP;
            else if (sts.is_insert || sts.is_find) state_in = S_READ;
            else state_in = S_RESP;
         end
         S_READ:  state_in = S_CHECK;
         S_CHECK: begin
            if (sts.is_insert) begin
               if (!sts.slot_active) state_in = S_WRITE;
               else if (sts.key_match || sts.wrapped) state_in = S_RESP;
               else state_in = S_READ;
            end else begin
               if (!sts.slot_active && !sts.slot_used) state_in = S_RESP;
               else if (sts.slot_active && sts.key_match) state_in = S_WRITE;
               else if (sts.wrapped) state_in = S_RESP;
               else state_in = S_READ;
            end
         end
         S_WRITE: state_in = S_RESP;
         S_RESP:  if (!sts.rsp_busy) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.status = ST_NOT_FOUND;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: cmd.clear_step = 1'b1;
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         S_DIV: cmd.div_step = 1'b1;
         S_FIX: begin
            cmd.fix = 1'b1;
            if (sts.is_insert && sts.limit_hit) begin
               cmd.set_status = 1'b1;
               cmd.status = ST_LIMIT;
            end
         end
         S_READ: cmd.rd = 1'b1;
         S_CHECK: begin
            if (sts.is_insert) begin
               if (!sts.slot_active) begin
                  cmd.set_status = 1'b1;
                  cmd.status = ST_OK;
               end else if (sts.key_match) begin
                  cmd.set_status = 1'b1;
                  cmd.status = ST_DUPLICATE;
               end else if (sts.wrapped) begin
                  cmd.set_status = 1'b1;
                  cmd.status = ST_FULL;
               end else begin
                  cmd.advance = 1'b1;
               end
            end else begin
               if (!sts.slot_active && !sts.slot_used) begin
                  cmd.advance = 1'b0;
               end else if (sts.slot_active && sts.key_match) begin
                  cmd.set_status = 1'b1;
                  cmd.status = ST_OK;
               end else if (!sts.wrapped) begin
                  cmd.advance = 1'b1;
               end
            end
         end
         S_WRITE: cmd.commit = 1'b1;
         S_RESP:  cmd.rsp_load = !sts.rsp_busy;
         default: cmd = '0;
      endcase
   end

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_load_div: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_DIV) else $error("no divide after load");
   a_commit_one: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> state_ff == S_RESP) else $error("commit not followed by response");
`endif

endmodule

[rtl/core/lpht_dp.sv]
// datapath: divider, probe pointer, slot memories and result register
module lpht_dp #(
   parameter int SLOTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lpht_pkg::cmd_type             cmd,
   output lpht_pkg::sts_type             sts,
   input  logic [lpht_pkg::OP_W-1:0]     req_operation,
   input  logic [lpht_pkg::KEY_W-1:0]    req_key,
   input  logic [lpht_pkg::PAY_W-1:0]    req_payload,
   input  logic                          csr_write,
   input  logic [lpht_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lpht_pkg::CSR_W-1:0]    csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lpht_pkg::STATUS_W-1:0] rsp_status,
   output logic [lpht_pkg::PAY_W-1:0]    rsp_found_payload,
   output logic [lpht_pkg::CNT_W-1:0]    rsp_entry_count
);
   import lpht_pkg::*;

   localparam int AW = $clog2(SLOTS);
   localparam int NW = AW + 1;
   localparam int DIV_BITS = 32;
   localparam int DW = $clog2(DIV_BITS + 1);

   logic [CSR_W-1:0] size_ff, max_ff;
   logic [NW-1:0]    n_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= CSR_W'(1021);
         max_ff  <= CSR_W'(1024);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TABLE_SIZE:  size_ff <= csr_data;
            CSR_MAX_ENTRIES: max_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (size_ff == '0) n_eff = NW'(1);
      else if (int'(size_ff) > SLOTS) n_eff = NW'(SLOTS);
      else n_eff = NW'(size_ff);
   end

   logic [OP_W-1:0]  op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [PAY_W-1:0] pay_ff;
   logic [KEY_W-1:0] quo_ff;
   logic [NW-1:0]    rem_ff;
   logic [DW-1:0]    dcnt_ff;
   logic [AW-1:0]    idx_ff, start_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [CNT_W-1:0] count_ff;
   logic [AW:0]      clr_ff;

   logic [KEY_W-1:0] abs_key;
   logic [NW:0]      trial;
   logic [NW-1:0]    rem_shift;
   logic [AW-1:0]    home, next_idx;

   assign abs_key = req_key[KEY_W-1] ? (~req_key + 1'b1) : req_key;
   assign rem_shift = NW'({rem_ff, quo_ff[KEY_W-1]});
   assign trial = {rem_ff, quo_ff[KEY_W-1]} - {1'b0, n_eff};

   always_comb begin
      if (key_ff[KEY_W-1] && rem_ff != '0) home = AW'(n_eff - rem_ff);
      else home = AW'(rem_ff);
   end

   always_comb begin
      if ({1'b0, idx_ff} + 1'b1 >= n_eff) next_idx = '0;
      else next_idx = idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_operation;
         key_ff <= req_key;
         pay_ff <= req_payload;
      end
      if (cmd.load) begin
         dcnt_ff <= '0;
         rem_ff  <= '0;
         quo_ff  <= abs_key;
      end else if (cmd.div_step) begin
         if (!trial[NW]) begin
            rem_ff <= NW'(trial);
            quo_ff <= {quo_ff[KEY_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift;
            quo_ff <= {quo_ff[KEY_W-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 1'b1;
      end
      if (cmd.fix) begin
         idx_ff   <= home;
         start_ff <= home;
      end else if (cmd.advance) begin
         idx_ff <= next_idx;
      end
      if (cmd.load) status_ff <= ST_NOT_FOUND;
      else if (cmd.set_status) status_ff <= cmd.status;
   end

   logic [KEY_W-1:0] mem_key [SLOTS];
   logic [PAY_W-1:0] mem_pay [SLOTS];
   logic [1:0]       mem_flag [SLOTS];
   logic [KEY_W-1:0] rd_key;
   logic [PAY_W-1:0] rd_pay;
   logic [1:0]       rd_flag;
   logic             clearing;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [1:0]       wr_flag;
   logic             is_ins;

   assign clearing = cmd.clear_step;
   assign is_ins = (op_ff == OP_INSERT);
   assign wr_en = clearing || (cmd.commit && op_ff != OP_SEARCH);
   assign wr_addr = clearing ? clr_ff[AW-1:0] : idx_ff;
   assign wr_flag = clearing ? 2'b00 : (is_ins ? 2'b11 : 2'b10);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_flag[wr_addr] <= wr_flag;
         if (clearing || is_ins) begin
            mem_key[wr_addr] <= clearing ? '0 : key_ff;
            mem_pay[wr_addr] <= clearing ? '0 : pay_ff;
         end
      end
      if (cmd.rd) begin
         rd_key  <= mem_key[idx_ff];
         rd_pay  <= mem_pay[idx_ff];
         rd_flag <= mem_flag[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (clearing) clr_ff <= clr_ff + 1'b1;
         if (cmd.commit) begin
            if (is_ins) count_ff <= count_ff + 1'b1;
            else if (op_ff == OP_DELETE && count_ff != '0) count_ff <= count_ff - 1'b1;
         end
      end
   end

   logic [PAY_W-1:0] found_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) found_ff <= '0;
      else if (cmd.set_status && cmd.status == ST_OK && op_ff == OP_SEARCH)
         found_ff <= rd_pay;
   end

   logic rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [PAY_W-1:0] rsp_pay_ff;
   logic [CNT_W-1:0] rsp_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_pay_ff    <= found_ff;
         rsp_cnt_ff    <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found_payload = rsp_pay_ff;
   assign rsp_entry_count = rsp_cnt_ff;

   assign sts.clear_done  = (clr_ff == (AW + 1)'(SLOTS - 1));
   assign sts.div_done    = (dcnt_ff == DW'(DIV_BITS - 1));
   assign sts.is_insert   = is_ins;
   assign sts.is_find     = (op_ff == OP_SEARCH) || (op_ff == OP_DELETE);
   assign sts.limit_hit   = ({1'b0, count_ff} + 1'b1) > {1'b0, max_ff};
   assign sts.slot_active = rd_flag[0];
   assign sts.slot_used   = rd_flag[1];
   assign sts.key_match   = (rd_key == key_ff);
   assign sts.wrapped     = (next_idx == start_ff);
   assign sts.rsp_busy    = rsp_valid_ff && !rsp_ready;

`ifndef ASSERT_OFF
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && is_ins |-> count_ff < max_ff) else $error("insert past limit");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |-> {1'b0, idx_ff} < n_eff) else $error("probe outside table");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status)) else $error("result changed while held");
`endif

endmodule
